>>> design/ppb_pkg.sv
// package for the percent pixel blend core: format codes, register indexes,
// channel layout functions and blend constants
// depends on nothing
package ppb_pkg;

    // pixel format codes
    localparam logic [1:0] FMT_565  = 2'd0;
    localparam logic [1:0] FMT_5551 = 2'd1;
    localparam logic [1:0] FMT_4444 = 2'd2;
    localparam logic [1:0] FMT_8888 = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_BLEND_RATE   = 2'd1;
    localparam logic [1:0] REG_INVERT_DEST  = 2'd2;

    localparam int NUM_CHAN   = 3;
    localparam int CHAN_W     = 8;
    localparam int RATE_W     = 7;
    localparam int SUM_W      = 15;
    localparam int PROD_W     = 28;
    localparam int PIXEL_W    = 32;
    localparam int RESULT_W   = 24;

    localparam logic [RATE_W-1:0] RATE_FULL  = 7'd100;
    localparam logic [SUM_W-1:0]  RATE_HALF  = 15'd50;

    // x / 100 == (x * 5243) >> 19 for every x below 25600
    localparam logic [12:0] RECIP_MUL   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [SUM_W-1:0]  wsum_t;

    function automatic chan_t chan_mask(logic [1:0] fmt, logic [1:0] ch);
        chan_t m;
        m = 8'hff;
        unique case (fmt)
            FMT_565:  m = (ch == 2'd1) ? 8'h3f : 8'h1f;
            FMT_5551: m = 8'h1f;
            FMT_4444: m = 8'h0f;
            FMT_8888: m = 8'hff;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] chan_shift(logic [1:0] fmt, logic [1:0] ch);
        logic [4:0] sh;
        sh = 5'd0;
        unique case (ch)
            2'd1:
            begin
                unique case (fmt)
                    FMT_565:  sh = 5'd5;
                    FMT_5551: sh = 5'd5;
                    FMT_4444: sh = 5'd4;
                    FMT_8888: sh = 5'd8;
                endcase
            end
            2'd2:
            begin
                unique case (fmt)
                    FMT_565:  sh = 5'd11;
                    FMT_5551: sh = 5'd10;
                    FMT_4444: sh = 5'd8;
                    FMT_8888: sh = 5'd16;
                endcase
            end
            default: sh = 5'd0;
        endcase
        return sh;
    endfunction

    function automatic chan_t chan_get(logic [PIXEL_W-1:0] px, logic [1:0] fmt,
                                       logic [1:0] ch);
        logic [PIXEL_W-1:0] shifted;
        shifted = px >> chan_shift(fmt, ch);
        return shifted[CHAN_W-1:0] & chan_mask(fmt, ch);
    endfunction

endpackage

>>> design/percent_pixel_blend_core.sv
// percent pixel blend core: the done strobe follows the start transfer through
// the stage registers below; one pixel accepted every cycle, busy is never raised
// stages: input register, weighted sum register (two small multiplies per
// channel), result register (reciprocal multiply for the divide by 100)
// rst_n clears pipeline valids and sets format 565, rate 100, no invert
// the receiver cannot stall: each result shows for one cycle with done
// depends on ppb_pkg
module percent_pixel_blend_core
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel command channel
    input  logic        start,
    output logic        busy,
    input  logic [31:0] source_color,
    input  logic [31:0] dest_pixel,
    // result channel
    output logic        done,
    output logic [23:0] blended_pixel,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    // configuration registers; rate is saturated at write time and its
    // complement kept so the datapath needs no subtract
    logic [1:0]                     pixel_format_reg;
    logic [ppb_pkg::RATE_W-1:0]     rate_reg;
    logic [ppb_pkg::RATE_W-1:0]     rate_inv_reg;
    logic                           invert_dest_reg;
    logic [ppb_pkg::RATE_W-1:0]     rate_next;

    // stage 1: input register
    logic                           in_valid_reg;
    logic [ppb_pkg::PIXEL_W-1:0]    src_reg;
    logic [ppb_pkg::PIXEL_W-1:0]    dst_reg;

    // stage 2: weighted channel sums
    logic                           sum_valid_reg;
    ppb_pkg::wsum_t                 sum_reg  [ppb_pkg::NUM_CHAN];
    ppb_pkg::wsum_t                 sum_next [ppb_pkg::NUM_CHAN];

    // stage 3: result register
    logic                           done_reg;
    logic [ppb_pkg::RESULT_W-1:0]   result_reg;
    logic [ppb_pkg::RESULT_W-1:0]   result_next;

    // every cycle takes a pixel and a config write
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign rate_next = (cfg_data > ppb_pkg::RATE_FULL) ? ppb_pkg::RATE_FULL : cfg_data;

    // config transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= ppb_pkg::FMT_565;
            rate_reg         <= ppb_pkg::RATE_FULL;
            rate_inv_reg     <= '0;
            invert_dest_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ppb_pkg::REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[1:0];
                ppb_pkg::REG_BLEND_RATE:
                begin
                    rate_reg     <= rate_next;
                    rate_inv_reg <= ppb_pkg::RATE_FULL - rate_next;
                end
                ppb_pkg::REG_INVERT_DEST:  invert_dest_reg <= cfg_data[0];
                default: ;  // unmapped index is dropped
            endcase
        end
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            sum_valid_reg <= in_valid_reg;
            done_reg      <= sum_valid_reg;
        end
    end

    // unpack, optional destination invert, weighted sum with rounding bias
    always_comb
    begin
        ppb_pkg::chan_t s;
        ppb_pkg::chan_t d;
        ppb_pkg::wsum_t ps;
        ppb_pkg::wsum_t pd;
        for (int i = 0; i < ppb_pkg::NUM_CHAN; i++)
        begin
            s = ppb_pkg::chan_get(src_reg, pixel_format_reg, 2'(i));
            d = ppb_pkg::chan_get(invert_dest_reg ? ~dst_reg : dst_reg,
                                  pixel_format_reg, 2'(i));
            ps = ppb_pkg::SUM_W'(s) * ppb_pkg::SUM_W'(rate_reg);
            pd = ppb_pkg::SUM_W'(d) * ppb_pkg::SUM_W'(rate_inv_reg);
            sum_next[i] = ps + pd + ppb_pkg::RATE_HALF;
        end
    end

    // divide by 100 through the reciprocal, then repack
    always_comb
    begin
        logic [ppb_pkg::PROD_W-1:0]   prod;
        ppb_pkg::chan_t               q;
        result_next = '0;
        for (int i = 0; i < ppb_pkg::NUM_CHAN; i++)
        begin
            prod = ppb_pkg::PROD_W'(sum_reg[i]) * ppb_pkg::PROD_W'(ppb_pkg::RECIP_MUL);
            q    = prod[ppb_pkg::RECIP_SHIFT +: ppb_pkg::CHAN_W];
            result_next = result_next
                        | (ppb_pkg::RESULT_W'(q)
                           << ppb_pkg::chan_shift(pixel_format_reg, 2'(i)));
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            src_reg <= source_color;
            dst_reg <= dest_pixel;
        end
        if (in_valid_reg)
        begin
            for (int i = 0; i < ppb_pkg::NUM_CHAN; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
        if (sum_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done          = done_reg;
    assign blended_pixel = result_reg;

endmodule
